### rtl/dpc_pkg.sv
// Shared types and constants of the DNA profile consensus block.
package dpc_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int COUNT_BITS  = 16;
   localparam int ADDR_BITS   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int PTR_BITS    = $clog2(MAX_COLUMNS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   typedef enum logic [1:0] {
      SLOT_A = 2'd0,
      SLOT_C = 2'd1,
      SLOT_G = 2'd2,
      SLOT_T = 2'd3
   } base_slot_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef count_type [3:0] count_word_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      count_word_type       data;
   } ram_wr_type;

   typedef struct packed {
      logic          hit;
      base_slot_type slot;
   } slot_code_type;

   function automatic slot_code_type decode_base(input logic [7:0] ch);
      slot_code_type code;
      code.hit  = 1'b1;
      code.slot = SLOT_A;
      case (ch)
         CHAR_A:  code.slot = SLOT_A;
         CHAR_C:  code.slot = SLOT_C;
         CHAR_G:  code.slot = SLOT_G;
         CHAR_T:  code.slot = SLOT_T;
         default: code.hit  = 1'b0;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] slot_char(input base_slot_type slot);
      logic [7:0] ch;
      case (slot)
         SLOT_A:  ch = CHAR_A;
         SLOT_C:  ch = CHAR_C;
         SLOT_G:  ch = CHAR_G;
         SLOT_T:  ch = CHAR_T;
         default: ch = CHAR_A;
      endcase
      return ch;
   endfunction

endpackage

### rtl/dna_profile_consensus_top.sv
// A query's count read and request fields are registered in stage 1, then the response loads
// into the output register, from which it can be taken.
// Throughput: one request per cycle; req_stall rises only while a query response is blocked.
// Add requests read the column, update and write it back in the next cycle; the last write is
// bypassed to a following read of the same column.
// Reset (synchronous) clears column pointer, profile length and pipeline valids; the count
// memory needs no clearing: first-string adds start at zero, queries report only its columns.
module dna_profile_consensus_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_base_char,
   input  logic        req_string_end,
   input  logic [9:0]  req_query_column,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_count_a,
   output logic [15:0] rsp_count_c,
   output logic [15:0] rsp_count_g,
   output logic [15:0] rsp_count_t,
   output logic [7:0]  rsp_consensus_char,
   output logic        rsp_column_valid
);

   logic [dpc_pkg::PTR_BITS-1:0] column_pointer_ff, column_pointer_in;
   logic [dpc_pkg::PTR_BITS-1:0] profile_length_ff, profile_length_in;
   logic                         length_fixed_ff, length_fixed_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_query_ff;
   logic                          s1_write_ff;
   logic                          s1_first_ff;
   logic                          s1_colvalid_ff;
   dpc_pkg::slot_code_type        s1_code_ff;
   logic [dpc_pkg::ADDR_BITS-1:0] s1_addr_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   dpc_pkg::count_word_type rsp_counts_ff;
   logic [7:0]              rsp_char_ff;
   logic                    rsp_colvalid_ff;

   logic                          req_accept;
   logic                          s1_block;
   logic                          rsp_load;
   logic [dpc_pkg::PTR_BITS-1:0]  limit;
   logic                          in_range;
   logic [dpc_pkg::PTR_BITS-1:0]  pointer_step;
   logic                          query_ok;

   dpc_pkg::ram_rd_type     ram_rd;
   dpc_pkg::ram_wr_type     ram_wr;
   dpc_pkg::count_word_type rd_word;
   dpc_pkg::count_word_type old_word;
   dpc_pkg::count_word_type new_word;
   dpc_pkg::base_slot_type  pick;
   dpc_pkg::count_type      best;

   assign s1_block   = s1_valid_ff && s1_query_ff && rsp_valid_ff && rsp_stall;
   assign req_stall  = s1_block;
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = s1_valid_ff && s1_query_ff && !s1_block;

   // column bookkeeping at accept
   always_comb begin
      limit        = length_fixed_ff ? profile_length_ff
                                     : dpc_pkg::PTR_BITS'(dpc_pkg::MAX_COLUMNS);
      in_range     = column_pointer_ff < limit;
      pointer_step = in_range ? column_pointer_ff + 1'b1 : column_pointer_ff;
      query_ok     = length_fixed_ff && (32'(req_query_column) < 32'(profile_length_ff));

      column_pointer_in = column_pointer_ff;
      profile_length_in = profile_length_ff;
      length_fixed_in   = length_fixed_ff;
      if (req_accept && (req_mode == dpc_pkg::MODE_ADD)) begin
         column_pointer_in = pointer_step;
         if (req_string_end) begin
            column_pointer_in = '0;
            if (!length_fixed_ff) begin
               profile_length_in = pointer_step;
               length_fixed_in   = 1'b1;
            end
         end
      end

      ram_rd.en   = req_accept;
      ram_rd.addr = (req_mode == dpc_pkg::MODE_QUERY) ? dpc_pkg::ADDR_BITS'(req_query_column)
                                                      : dpc_pkg::ADDR_BITS'(column_pointer_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pointer_ff <= '0;
         profile_length_ff <= '0;
         length_fixed_ff   <= 1'b0;
      end else begin
         column_pointer_ff <= column_pointer_in;
         profile_length_ff <= profile_length_in;
         length_fixed_ff   <= length_fixed_in;
      end
   end

   assign s1_valid_in = req_accept ? 1'b1 : (s1_block ? s1_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_query_ff    <= (req_mode == dpc_pkg::MODE_QUERY);
         s1_write_ff    <= in_range;
         s1_first_ff    <= !length_fixed_ff;
         s1_colvalid_ff <= query_ok;
         s1_code_ff     <= dpc_pkg::decode_base(req_base_char);
         s1_addr_ff     <= ram_rd.addr;
      end
   end

   dpc_count_ram u_count_ram (
      .clock   (clock),
      .reset   (reset),
      .rd      (ram_rd),
      .wr      (ram_wr),
      .rd_word (rd_word)
   );

   // first-string columns have never been written: they start from zero
   always_comb begin
      old_word = s1_first_ff ? '0 : rd_word;
      new_word = old_word;
      if (s1_code_ff.hit && (old_word[s1_code_ff.slot] != dpc_pkg::COUNT_MAX)) begin
         new_word[s1_code_ff.slot] = old_word[s1_code_ff.slot] + 1'b1;
      end
      ram_wr.en   = s1_valid_ff && !s1_query_ff && s1_write_ff;
      ram_wr.addr = s1_addr_ff;
      ram_wr.data = new_word;
   end

   // consensus: strict greater keeps the earlier base on ties
   always_comb begin
      pick = dpc_pkg::SLOT_A;
      best = rd_word[dpc_pkg::SLOT_A];
      if (rd_word[dpc_pkg::SLOT_C] > best) begin
         pick = dpc_pkg::SLOT_C;
         best = rd_word[dpc_pkg::SLOT_C];
      end
      if (rd_word[dpc_pkg::SLOT_G] > best) begin
         pick = dpc_pkg::SLOT_G;
         best = rd_word[dpc_pkg::SLOT_G];
      end
      if (rd_word[dpc_pkg::SLOT_T] > best) begin
         pick = dpc_pkg::SLOT_T;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_colvalid_ff <= s1_colvalid_ff;
         rsp_counts_ff   <= s1_colvalid_ff ? rd_word : '0;
         rsp_char_ff     <= s1_colvalid_ff ? dpc_pkg::slot_char(pick) : 8'h00;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_count_a        = 16'(rsp_counts_ff[dpc_pkg::SLOT_A]);
   assign rsp_count_c        = 16'(rsp_counts_ff[dpc_pkg::SLOT_C]);
   assign rsp_count_g        = 16'(rsp_counts_ff[dpc_pkg::SLOT_G]);
   assign rsp_count_t        = 16'(rsp_counts_ff[dpc_pkg::SLOT_T]);
   assign rsp_consensus_char = rsp_char_ff;
   assign rsp_column_valid   = rsp_colvalid_ff;

endmodule

### rtl/dpc_count_ram.sv
// Count store: synchronous-read memory with bypass of the last write.
module dpc_count_ram (
   input  logic                   clock,
   input  logic                   reset,
   input  dpc_pkg::ram_rd_type    rd,
   input  dpc_pkg::ram_wr_type    wr,
   output dpc_pkg::count_word_type rd_word
);

   dpc_pkg::count_word_type mem [dpc_pkg::MAX_COLUMNS];

   dpc_pkg::count_word_type          rd_data_ff;
   logic [dpc_pkg::ADDR_BITS-1:0]    rd_addr_ff;
   logic                             wr_valid_ff;
   logic [dpc_pkg::ADDR_BITS-1:0]    wr_addr_ff;
   dpc_pkg::count_word_type          wr_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
         rd_addr_ff <= rd.addr;
      end
   end

   // last write is always the newest value of its entry
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (wr.en) begin
         wr_valid_ff <= 1'b1;
      end
      if (wr.en) begin
         wr_addr_ff <= wr.addr;
         wr_data_ff <= wr.data;
      end
   end

   assign rd_word = (wr_valid_ff && (wr_addr_ff == rd_addr_ff)) ? wr_data_ff : rd_data_ff;

endmodule

### rtl/dpc_checker.sv
// Port-level checker for the DNA profile consensus block, with its bind.
module dpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_count_a,
   input logic [15:0] rsp_count_c,
   input logic [15:0] rsp_count_g,
   input logic [15:0] rsp_count_t,
   input logic [7:0]  rsp_consensus_char,
   input logic        rsp_column_valid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count_a) && $stable(rsp_count_c)
         && $stable(rsp_count_g) && $stable(rsp_count_t) && $stable(rsp_consensus_char)
         && $stable(rsp_column_valid))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_column_valid |-> rsp_count_a == 16'd0 && rsp_count_c == 16'd0
         && rsp_count_g == 16'd0 && rsp_count_t == 16'd0 && rsp_consensus_char == 8'h00)
      else $error("invalid column response not zero");

   a_char_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_column_valid |-> rsp_consensus_char == dpc_pkg::CHAR_A
         || rsp_consensus_char == dpc_pkg::CHAR_C || rsp_consensus_char == dpc_pkg::CHAR_G
         || rsp_consensus_char == dpc_pkg::CHAR_T)
      else $error("consensus is not a base");

   a_a_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_column_valid && rsp_consensus_char == dpc_pkg::CHAR_A
         |-> rsp_count_a >= rsp_count_c && rsp_count_a >= rsp_count_g
         && rsp_count_a >= rsp_count_t)
      else $error("consensus A is not the maximum");

endmodule

bind dna_profile_consensus_top dpc_checker u_dpc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_count_a        (rsp_count_a),
   .rsp_count_c        (rsp_count_c),
   .rsp_count_g        (rsp_count_g),
   .rsp_count_t        (rsp_count_t),
   .rsp_consensus_char (rsp_consensus_char),
   .rsp_column_valid   (rsp_column_valid)
);

### tb/dna_profile_consensus_top_test.sv
// Self-checking testbench of dna_profile_consensus_top: profile build and column queries.
module dna_profile_consensus_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   STALL_LIMIT = 2000;
   localparam logic [7:0] BASE_LETTER [4] = '{dpc_pkg::CHAR_A, dpc_pkg::CHAR_C,
                                               dpc_pkg::CHAR_G, dpc_pkg::CHAR_T};

   typedef struct packed {
      logic       mode;
      logic [7:0] base_char;
      logic       string_end;
      logic [9:0] query_column;
   } request_type;

   typedef struct packed {
      dpc_pkg::count_type count_a;
      dpc_pkg::count_type count_c;
      dpc_pkg::count_type count_g;
      dpc_pkg::count_type count_t;
      logic [7:0]         consensus_char;
      logic               column_valid;
   } column_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = dpc_pkg::MODE_ADD;
   logic [7:0]  req_base_char = '0;
   logic        req_string_end = 1'b0;
   logic [9:0]  req_query_column = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_count_a;
   logic [15:0] rsp_count_c;
   logic [15:0] rsp_count_g;
   logic [15:0] rsp_count_t;
   logic [7:0]  rsp_consensus_char;
   logic        rsp_column_valid;

   dna_profile_consensus_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_base_char      (req_base_char),
      .req_string_end     (req_string_end),
      .req_query_column   (req_query_column),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_count_a        (rsp_count_a),
      .rsp_count_c        (rsp_count_c),
      .rsp_count_g        (rsp_count_g),
      .rsp_count_t        (rsp_count_t),
      .rsp_consensus_char (rsp_consensus_char),
      .rsp_column_valid   (rsp_column_valid)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stimulus and profile shadow
   request_type        request_q [$];
   column_report_type  column_reports [$];
   request_type        cur_request;
   dpc_pkg::count_type tally [dpc_pkg::MAX_COLUMNS][4];
   int unsigned        col_ptr;
   int unsigned        prof_len;
   bit                 len_fixed;
   int unsigned        send_idle_pct = 28;
   int unsigned        recv_idle_pct = 66;
   int                 n_queued;
   int                 n_accepted;
   int                 n_adds;
   int                 n_queries;
   int                 n_profiled;
   int                 fail_count;
   int                 idle_cycles;

   function automatic void apply_char(logic [7:0] ch, logic last);
      int unsigned limit;
      int          slot;
      limit = len_fixed ? prof_len : dpc_pkg::MAX_COLUMNS;
      slot = -1;
      for (int k = 0; k < 4; k++)
         if (ch == BASE_LETTER[k]) slot = k;
      if (col_ptr < limit) begin
         if (slot >= 0 && tally[col_ptr][slot] != dpc_pkg::COUNT_MAX)
            tally[col_ptr][slot] = tally[col_ptr][slot] + 1'b1;
         col_ptr++;
      end
      if (last) begin
         if (!len_fixed) begin
            prof_len  = col_ptr;
            len_fixed = 1'b1;
         end
         col_ptr = 0;
      end
   endfunction

   function automatic column_report_type column_summary(int unsigned col);
      column_report_type r;
      int                pick;
      r = '0;
      if (len_fixed && col < prof_len) begin
         pick = 0;
         for (int k = 1; k < 4; k++)
            if (tally[col][k] > tally[col][pick]) pick = k;
         r.count_a        = tally[col][0];
         r.count_c        = tally[col][1];
         r.count_g        = tally[col][2];
         r.count_t        = tally[col][3];
         r.consensus_char = BASE_LETTER[pick];
         r.column_valid   = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [7:0] rand_base();
      if ($urandom_range(99) < 80) return BASE_LETTER[$urandom_range(3)];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [9:0] rand_column();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return 10'($urandom_range(47));
      if (roll < 90) return 10'($urandom_range(1023));
      return $urandom_range(1) ? 10'd1023 : 10'd0;
   endfunction

   task automatic push_char(logic [7:0] ch, logic last);
      request_type r;
      r.mode         = dpc_pkg::MODE_ADD;
      r.base_char    = ch;
      r.string_end   = last;
      r.query_column = 10'($urandom_range(1023));
      request_q = {request_q, r};
      n_queued++;
   endtask

   task automatic push_query(logic [9:0] col);
      request_type r;
      r.mode         = dpc_pkg::MODE_QUERY;
      r.base_char    = 8'($urandom_range(255));
      r.string_end   = 1'($urandom_range(1));
      r.query_column = col;
      request_q = {request_q, r};
      n_queued++;
   endtask

   task automatic push_string(int len);
      for (int i = 0; i < len; i++)
         push_char(rand_base(), i == len - 1);
   endtask

   task automatic push_random(int count);
      int start;
      int roll;
      start = n_queued;
      while (n_queued - start < count) begin
         roll = $urandom_range(99);
         if (roll < 40) push_query(rand_column());
         else if (roll < 95) push_string($urandom_range(1, 40));
         else push_string($urandom_range(41, 120));
      end
   endtask

   // hold off the sender until every request is in and every response is back
   task automatic drain();
      wait (n_accepted == n_queued && column_reports.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            n_accepted++;
            if (cur_request.mode == dpc_pkg::MODE_ADD) begin
               n_adds++;
               apply_char(cur_request.base_char, cur_request.string_end);
            end else begin
               n_queries++;
               column_reports = {column_reports, column_summary(cur_request.query_column)};
            end
         end
         if (!req_valid || !req_stall) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_request = request_q.pop_front();
               req_mode         <= cur_request.mode;
               req_base_char    <= cur_request.base_char;
               req_string_end   <= cur_request.string_end;
               req_query_column <= cur_request.query_column;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      column_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (column_reports.size() == 0) begin
            fail_count++;
            $error("response with no query pending");
         end else begin
            want = column_reports.pop_front();
            if (want.column_valid) n_profiled++;
            if (rsp_count_a !== want.count_a)
               flag_mismatch("count_a", want.count_a, rsp_count_a);
            if (rsp_count_c !== want.count_c)
               flag_mismatch("count_c", want.count_c, rsp_count_c);
            if (rsp_count_g !== want.count_g)
               flag_mismatch("count_g", want.count_g, rsp_count_g);
            if (rsp_count_t !== want.count_t)
               flag_mismatch("count_t", want.count_t, rsp_count_t);
            if (rsp_consensus_char !== want.consensus_char)
               flag_mismatch("consensus_char", want.consensus_char, rsp_consensus_char);
            if (rsp_column_valid !== want.column_valid)
               flag_mismatch("column_valid", want.column_valid, rsp_column_valid);
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog: no request or response moving for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("dna_profile_consensus_top regression: fail");
         $finish;
      end
   end

   initial begin
      for (int c = 0; c < dpc_pkg::MAX_COLUMNS; c++)
         for (int k = 0; k < 4; k++)
            tally[c][k] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // queries before the profile length is fixed
      push_query(10'd0);
      push_query(10'd1023);
      // first string of 40 characters with non-base ones; a query in the middle is unprofiled
      for (int i = 0; i < 8; i++) push_char(rand_base(), 1'b0);
      push_query(10'd2);
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b0);
      push_char(8'h61, 1'b0);
      push_string(29);
      push_query(10'd0);
      push_query(10'd39);
      push_query(10'd40);
      push_query(10'd1023);
      // short string with a non-base character, leaves the tail untouched
      push_char(dpc_pkg::CHAR_A, 1'b0);
      push_char(dpc_pkg::CHAR_C, 1'b0);
      push_char(dpc_pkg::CHAR_G, 1'b0);
      push_char(dpc_pkg::CHAR_T, 1'b0);
      push_char(8'h4E, 1'b1);
      push_query(10'd3);
      push_query(10'd4);
      // later string longer than the profile
      push_string(45);
      push_query(10'd39);

      push_random(215);
      drain();

      send_idle_pct = 66;
      recv_idle_pct = 28;
      push_random(215);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random(215);
      drain();
      repeat (10) @(posedge clock);

      if (column_reports.size() != 0) begin
         fail_count++;
         $error("%0d query responses never arrived", column_reports.size());
      end
      $display("Ran %0d adds and %0d queries (%0d on profiled columns), profile length %0d,",
               n_adds, n_queries, n_profiled, prof_len);
      $display("with short, overlong and non-base strings under three idle mixes.");
      if (fail_count == 0)
         $display("dna_profile_consensus_top regression: pass");
      else
         $display("dna_profile_consensus_top regression: fail");
      $finish;
   end

endmodule
